// ===== rtl/multichannel_moving_average_macros.svh =====
// assertion macros shared by the rtl
`ifndef MULTICHANNEL_MOVING_AVERAGE_MACROS_SVH
`define MULTICHANNEL_MOVING_AVERAGE_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define MMA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define MMA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define MMA_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define MMA_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/mma_pkg.sv =====
package mma_pkg;

    localparam int SAMPLE_WIDTH   = 24;
    localparam int CHANNEL_WIDTH  = 5;
    localparam int WINDOW_WIDTH   = 7;
    localparam int WINDOW_RESET   = 5;
    localparam int CHANNELS_DEF   = 32;
    localparam int MAX_WINDOW_DEF = 64;

    typedef struct packed {
        logic [CHANNEL_WIDTH-1:0]       channel;
        logic signed [SAMPLE_WIDTH-1:0] sample;
        logic                           row_end;
    } t_in_beat;

    typedef struct packed {
        logic [CHANNEL_WIDTH-1:0]       out_channel;
        logic signed [SAMPLE_WIDTH-1:0] average;
        logic                           out_row_end;
    } t_out_beat;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

// ===== rtl/mma_div.sv =====
`include "multichannel_moving_average_macros.svh"

module mma_div #(
    parameter int MAX_WINDOW = mma_pkg::MAX_WINDOW_DEF
) (
    input  logic                                                   i_clk,
    input  logic                                                   i_rst_n,
    input  logic                                                   i_start,
    input  logic signed [mma_pkg::SAMPLE_WIDTH+$clog2(MAX_WINDOW):0] i_dividend,
    input  logic [$clog2(MAX_WINDOW+1)-1:0]                        i_divisor,
    output mma_pkg::t_div_stat                                     o_stat,
    output logic signed [mma_pkg::SAMPLE_WIDTH-1:0]                o_quotient
);
    import mma_pkg::*;

    localparam int SUM_W = SAMPLE_WIDTH + $clog2(MAX_WINDOW) + 1;
    localparam int WIN_W = $clog2(MAX_WINDOW + 1);
    localparam int CNT_W = $clog2(SUM_W + 1);
    localparam logic [SUM_W-1:0] LIM = SUM_W'(1) << (SAMPLE_WIDTH - 1);

    logic [SUM_W-1:0] r_mag;
    logic [WIN_W-1:0] r_rem;
    logic             r_neg;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [SUM_W-1:0] n_abs;
    logic [SUM_W-1:0] n_negmag;
    logic [WIN_W:0]   n_shift;
    logic [WIN_W:0]   n_diff;
    logic             n_qbit;

    assign n_abs   = i_dividend[SUM_W-1] ? (SUM_W'(0) - $unsigned(i_dividend))
                                         : $unsigned(i_dividend);
    assign n_shift = {r_rem, r_mag[SUM_W-1]};
    assign n_qbit  = (n_shift >= {1'b0, i_divisor});
    assign n_diff  = n_shift - {1'b0, i_divisor};

    // one quotient bit per cycle, restoring
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(SUM_W);
                r_rem  <= '0;
                r_mag  <= n_abs;
                r_neg  <= i_dividend[SUM_W-1];
            end else if (r_busy) begin
                r_rem <= n_qbit ? n_diff[WIN_W-1:0] : n_shift[WIN_W-1:0];
                r_mag <= {r_mag[SUM_W-2:0], n_qbit};
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // sign restore and saturation
    always_comb begin
        n_negmag = SUM_W'(0) - r_mag;
        if (!r_neg) begin
            if (r_mag >= LIM) o_quotient = $signed({1'b0, {(SAMPLE_WIDTH-1){1'b1}}});
            else              o_quotient = $signed(r_mag[SAMPLE_WIDTH-1:0]);
        end else begin
            if (r_mag > LIM)  o_quotient = $signed({1'b1, {(SAMPLE_WIDTH-1){1'b0}}});
            else              o_quotient = $signed(n_negmag[SAMPLE_WIDTH-1:0]);
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

    `MMA_ASSERT_NXT(a_start_busy, i_clk, i_rst_n, i_start, r_busy)
    `MMA_ASSERT_IMP(a_done_idle, i_clk, i_rst_n, r_done, !r_busy)
    `MMA_ASSERT_IMP(a_no_restart, i_clk, i_rst_n, i_start, !r_busy)

endmodule

// ===== rtl/multichannel_moving_average.sv =====
// Multichannel moving average. Samples arrive one channel per beat, row_end on the last
// beat of a row. Each channel keeps its last window_length samples in a ring memory and
// a running sum; from the row that completes the first full window on, each beat with a
// channel below CHANNELS yields that channel's sum divided by the window, truncated toward
// zero and saturated to the sample range. Beats with a larger channel are dropped, row_end
// included. The input stalls while a beat is in progress: a beat that yields an average
// waits for the bit-serial divider, which makes one quotient bit a cycle, and for room in
// the result register; a beat with no average leaves after its update. The result register
// lets the next beat in while an average waits downstream. After reset the ring memory is
// cleared one entry a cycle, and the input stalls until every entry is cleared.
// Write window_length only while idle.
`include "multichannel_moving_average_macros.svh"

module multichannel_moving_average #(
    parameter int CHANNELS   = mma_pkg::CHANNELS_DEF,
    parameter int MAX_WINDOW = mma_pkg::MAX_WINDOW_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [mma_pkg::WINDOW_WIDTH-1:0] i_cfg_wdata,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  mma_pkg::t_in_beat                i_in,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output mma_pkg::t_out_beat               o_out
);
    import mma_pkg::*;

    localparam int SUM_W = SAMPLE_WIDTH + $clog2(MAX_WINDOW) + 1;
    localparam int WIN_W = $clog2(MAX_WINDOW + 1);
    localparam int RP_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CI_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int DEPTH = CHANNELS * MAX_WINDOW;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_UPDATE,
        S_DIV,
        S_HOLD
    } t_state;

    t_state                   r_state;
    logic [AW-1:0]            r_clr;
    logic [WINDOW_WIDTH-1:0]  r_window;
    logic [RP_W-1:0]          r_rp;
    logic [WIN_W-1:0]         r_rows;
    t_in_beat                 r_item;
    logic                     r_out_valid;
    t_out_beat                r_out;

    logic signed [SAMPLE_WIDTH-1:0] r_hist [DEPTH];
    logic signed [SAMPLE_WIDTH-1:0] r_hist_rd;
    logic signed [SUM_W-1:0]        r_sums [CHANNELS];
    logic signed [SUM_W-1:0]        r_sum_rd;
    logic [CHANNELS-1:0]            r_sum_vld;
    logic                           r_sum_vld_rd;

    logic [WIN_W-1:0]        w_eff;
    logic [RP_W-1:0]         rp_eff;
    logic [RP_W-1:0]         n_rp;
    logic [WIN_W-1:0]        n_rows;
    logic                    in_accept;
    logic                    ch_ok;
    logic                    emit;
    logic                    out_free;
    logic                    out_load;
    logic                    upd;
    logic                    clr;
    logic [AW-1:0]           rd_addr;
    logic [AW-1:0]           wr_addr;
    logic [CI_W-1:0]         rd_idx;
    logic [CI_W-1:0]         wr_idx;
    logic signed [SUM_W-1:0] sum_old;
    logic signed [SUM_W-1:0] n_sum;
    t_div_stat               div_stat;
    logic signed [SAMPLE_WIDTH-1:0] div_quot;

    // window clamped to 1..MAX_WINDOW
    always_comb begin
        if (r_window == '0)                  w_eff = WIN_W'(1);
        else if (int'(r_window) > MAX_WINDOW) w_eff = WIN_W'(MAX_WINDOW);
        else                                 w_eff = WIN_W'(r_window);
    end

    assign in_accept = i_in_valid && !o_in_stall;
    assign ch_ok     = (int'(i_in.channel) < CHANNELS);
    assign rp_eff    = (WIN_W'(r_rp) >= w_eff) ? '0 : r_rp;
    assign rd_addr   = AW'(int'(rp_eff) * CHANNELS + int'(i_in.channel));
    assign wr_addr   = AW'(int'(r_rp) * CHANNELS + int'(r_item.channel));
    assign rd_idx    = CI_W'(i_in.channel);
    assign wr_idx    = CI_W'(r_item.channel);
    assign upd       = (r_state == S_UPDATE);
    assign clr       = (r_state == S_CLEAR);

    assign sum_old = r_sum_vld_rd ? r_sum_rd : '0;
    assign n_sum   = sum_old
                   + {{(SUM_W-SAMPLE_WIDTH){r_item.sample[SAMPLE_WIDTH-1]}}, r_item.sample}
                   - {{(SUM_W-SAMPLE_WIDTH){r_hist_rd[SAMPLE_WIDTH-1]}}, r_hist_rd};

    assign emit   = ({1'b0, r_rows} + (WIN_W+1)'(1)) >= {1'b0, w_eff};
    assign n_rp   = ((WIN_W'(r_rp) + WIN_W'(1)) == w_eff) ? '0 : r_rp + RP_W'(1);
    assign n_rows = (r_rows < w_eff) ? r_rows + WIN_W'(1) : w_eff;

    assign out_free = !r_out_valid || !i_out_stall;
    assign out_load = ((r_state == S_DIV && div_stat.done) || r_state == S_HOLD) && out_free;

    // ring memory
    always_ff @(posedge i_clk) begin
        if (in_accept && ch_ok) r_hist_rd <= r_hist[rd_addr];
        if (clr) r_hist[r_clr] <= '0;
        else if (upd) r_hist[wr_addr] <= r_item.sample;
    end

    // running sums
    always_ff @(posedge i_clk) begin
        if (in_accept && ch_ok) r_sum_rd <= r_sums[rd_idx];
        if (upd) r_sums[wr_idx] <= n_sum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_vld <= '0;
        end else begin
            if (in_accept && ch_ok) r_sum_vld_rd <= r_sum_vld[rd_idx];
            if (upd) r_sum_vld[wr_idx] <= 1'b1;
        end
    end

    mma_div #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (upd && emit),
        .i_dividend (n_sum),
        .i_divisor  (w_eff),
        .o_stat     (div_stat),
        .o_quotient (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_window    <= WINDOW_WIDTH'(WINDOW_RESET);
            r_rp        <= '0;
            r_rows      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) r_window <= i_cfg_wdata;
            if (out_load) r_out_valid <= 1'b1;
            else if (!i_out_stall) r_out_valid <= 1'b0;
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == AW'(DEPTH - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (in_accept && ch_ok) begin
                        r_item  <= i_in;
                        r_rp    <= rp_eff;
                        r_state <= S_UPDATE;
                    end
                end
                S_UPDATE: begin
                    if (r_item.row_end) begin
                        r_rp   <= n_rp;
                        r_rows <= n_rows;
                    end
                    r_state <= emit ? S_DIV : S_IDLE;
                end
                S_DIV: begin
                    if (div_stat.done) begin
                        if (out_free) begin
                            r_out.out_channel <= r_item.channel;
                            r_out.average     <= div_quot;
                            r_out.out_row_end <= r_item.row_end;
                            r_state           <= S_IDLE;
                        end else begin
                            r_state <= S_HOLD;
                        end
                    end
                end
                S_HOLD: begin
                    if (out_free) begin
                        r_out.out_channel <= r_item.channel;
                        r_out.average     <= div_quot;
                        r_out.out_row_end <= r_item.row_end;
                        r_state           <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    `MMA_ASSERT_IMP(a_done_in_div, i_clk, i_rst_n, div_stat.done, r_state == S_DIV)
    `MMA_ASSERT_IMP(a_hold_full, i_clk, i_rst_n, r_state == S_HOLD, r_out_valid)
    `MMA_ASSERT_IMP(a_rows_max, i_clk, i_rst_n, 1'b1, r_rows <= WIN_W'(MAX_WINDOW))

endmodule

// ===== bench/tb_multichannel_moving_average.sv =====
module tb_multichannel_moving_average;
    timeunit 1ns;
    timeprecision 1ps;

    import mma_pkg::*;

    localparam int CHANNELS     = CHANNELS_DEF;
    localparam int MAX_WINDOW   = MAX_WINDOW_DEF;
    localparam int FIRST_WINDOW = 4;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 600000;
    localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_HI = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_LO = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    cfg_we;
    logic [WINDOW_WIDTH-1:0] cfg_wdata;
    logic                    in_valid;
    logic                    o_in_stall;
    t_in_beat                in_beat;
    logic                    o_out_valid;
    logic                    out_stall;
    t_out_beat               o_out;

    multichannel_moving_average dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (in_beat),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out       (o_out)
    );

    // predictor state
    logic [WINDOW_WIDTH-1:0]        win_reg;
    logic signed [SAMPLE_WIDTH-1:0] sample_ring [CHANNELS*MAX_WINDOW];
    longint                         channel_sums [CHANNELS];
    int                             filled_rows;
    int                             ring_row;

    t_out_beat expected_averages[$];
    int        mismatches = 0;
    int        cycle_count = 0;
    bit        calm;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic int idle_gap();
        return calm ? 0 : $urandom_range(0, 6);
    endfunction

    function automatic t_in_beat make_beat(input int ch, input logic signed [SAMPLE_WIDTH-1:0] s,
                                           input bit last);
        t_in_beat b;
        b.channel = ch[CHANNEL_WIDTH-1:0];
        b.sample  = s;
        b.row_end = last;
        return b;
    endfunction

    function automatic logic signed [SAMPLE_WIDTH-1:0] rand_sample();
        bit [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 7))
            0: return SAMPLE_HI;
            1: return SAMPLE_LO;
            2: return '0;
            default: return r[SAMPLE_WIDTH-1:0];
        endcase
    endfunction

    function automatic void predict_average(input t_in_beat b);
        int        w;
        int        slot;
        longint    s;
        longint    avg;
        longint    lim;
        bit        fire;
        t_out_beat r;
        if (win_reg == 0) w = 1;
        else if (win_reg > MAX_WINDOW) w = MAX_WINDOW;
        else w = int'(win_reg);
        lim = longint'(1) <<< (SAMPLE_WIDTH - 1);
        if (ring_row >= w) ring_row = 0;
        slot = ring_row * CHANNELS + int'(b.channel);
        s = $signed(b.sample);
        channel_sums[b.channel] += s - longint'(sample_ring[slot]);
        sample_ring[slot] = b.sample;
        fire = (filled_rows + 1 >= w);
        avg = channel_sums[b.channel] / w;
        if (avg > lim - 1) avg = lim - 1;
        if (avg < -lim) avg = -lim;
        if (b.row_end) begin
            ring_row = (ring_row + 1) % w;
            filled_rows = (filled_rows < w) ? filled_rows + 1 : w;
        end
        if (fire) begin
            r.out_channel = b.channel;
            r.average     = avg[SAMPLE_WIDTH-1:0];
            r.out_row_end = b.row_end;
            expected_averages = {expected_averages, r};
        end
    endfunction

    task automatic send_beat(input t_in_beat b);
        int gap;
        if ($urandom_range(0, 39) == 0) calm = !calm;
        gap = idle_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_beat  <= b;
        do @(posedge i_clk); while (o_in_stall);
        predict_average(b);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (expected_averages.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_window(input logic [WINDOW_WIDTH-1:0] v);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        win_reg = v;
    endtask

    // every channel exactly once per row until the ring is full
    task automatic test_first_window();
        int order [CHANNELS];
        int j;
        int t;
        set_window(7'(FIRST_WINDOW));
        for (int row = 0; row < FIRST_WINDOW; row++) begin
            for (int k = 0; k < CHANNELS; k++) order[k] = k;
            for (int k = CHANNELS - 1; k > 0; k--) begin
                j = $urandom_range(0, k);
                t = order[k];
                order[k] = order[j];
                order[j] = t;
            end
            for (int k = 0; k < CHANNELS; k++)
                send_beat(make_beat(order[k], rand_sample(), k == CHANNELS - 1));
        end
    endtask

    // sample extremes, duplicate and missing channels, one-beat rows
    task automatic test_field_extremes();
        send_beat(make_beat(0, SAMPLE_HI, 0));
        send_beat(make_beat(CHANNELS - 1, SAMPLE_LO, 0));
        send_beat(make_beat(0, SAMPLE_LO, 0));
        send_beat(make_beat(15, '0, 0));
        send_beat(make_beat(16, -24'sd1, 0));
        send_beat(make_beat(CHANNELS - 1, SAMPLE_HI, 1));
        send_beat(make_beat(CHANNELS - 1, SAMPLE_LO, 1));
        send_beat(make_beat(0, SAMPLE_HI, 1));
        send_beat(make_beat(21, 24'sh555555, 0));
        send_beat(make_beat(10, 24'shaaaaaa, 0));
        send_beat(make_beat(10, SAMPLE_HI, 1));
        send_beat(make_beat(5, SAMPLE_HI, 1));
    endtask

    task automatic test_random_traffic(input int n);
        int sent;
        int len;
        sent = 0;
        while (sent < n) begin
            if ($urandom_range(0, 1) == 0) begin
                len = $urandom_range(1, CHANNELS);
                for (int k = 0; k < len; k++)
                    send_beat(make_beat(k, rand_sample(), k == len - 1));
                sent += len;
            end else begin
                send_beat(make_beat($urandom_range(0, CHANNELS - 1), rand_sample(),
                                    $urandom_range(0, 5) == 0));
                sent++;
            end
        end
    endtask

    task automatic test_results_pause();
        test_random_traffic(40);
        drain();
        test_random_traffic(40);
    endtask

    // window grows past the maximum, then shrinks down to the clamped zero and ends at one
    task automatic test_window_changes();
        set_window(7'd127);
        test_random_traffic(60);
        set_window(7'd17);
        test_random_traffic(60);
        set_window(7'd5);
        test_random_traffic(60);
        set_window(7'd0);
        test_random_traffic(60);
        set_window(7'd1);
        test_random_traffic(60);
    endtask

    // result side: random stalls and in-order check
    initial begin
        int        hold;
        t_out_beat want;
        hold = 0;
        out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !out_stall) begin
                if (expected_averages.size() == 0) begin
                    $error("unexpected average beat on channel %0d", o_out.out_channel);
                    mismatches++;
                end else begin
                    want = expected_averages.pop_front();
                    if (o_out.out_channel !== want.out_channel) begin
                        $error("out_channel: expected %0d, got %0d",
                               want.out_channel, o_out.out_channel);
                        mismatches++;
                    end
                    if (o_out.average !== want.average) begin
                        $error("average: expected %0d, got %0d", want.average, o_out.average);
                        mismatches++;
                    end
                    if (o_out.out_row_end !== want.out_row_end) begin
                        $error("out_row_end: expected %0d, got %0d",
                               want.out_row_end, o_out.out_row_end);
                        mismatches++;
                    end
                end
                hold = idle_gap();
            end else if (hold > 0) begin
                hold--;
            end else if ($urandom_range(0, 15) == 0) begin
                hold = idle_gap();
            end
            out_stall <= (hold > 0);
        end
    end

    initial begin
        calm        = 1'b0;
        win_reg     = 7'(WINDOW_RESET);
        filled_rows = 0;
        ring_row    = 0;
        foreach (sample_ring[k]) sample_ring[k] = '0;
        foreach (channel_sums[k]) channel_sums[k] = 0;
        i_rst_n   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        in_valid  <= 1'b0;
        in_beat   <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_first_window();
        test_field_extremes();
        test_random_traffic(60);
        test_results_pause();
        test_window_changes();
        drain();

        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== multichannel_moving_average.f =====
+incdir+rtl
rtl/mma_pkg.sv
rtl/mma_div.sv
rtl/multichannel_moving_average.sv
bench/tb_multichannel_moving_average.sv
